FILE: rtl/core/mrslz_pkg.sv
`timescale 1ns / 1ps

package mrslz_pkg;

    // Field widths fixed by the interface
    localparam int unsigned VAL_W = 32;
    localparam int unsigned CNT_W = 4;
    localparam int unsigned ROW_W = 3;

    // One beat of store read data tagged with its place in the matrix
    typedef struct packed {
        logic             valid;
        logic             first_col;
        logic             last_col;
        logic [ROW_W-1:0] row;
    } t_beat;

    // Entry of the sorted row order table
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [CNT_W-1:0] cnt;
    } t_order;

    // One result item
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } t_res;

endpackage

FILE: rtl/core/mrslz_store.sv
`timescale 1ns / 1ps

module mrslz_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [mrslz_pkg::VAL_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [mrslz_pkg::VAL_W-1:0] o_rdata
);

    logic [mrslz_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [mrslz_pkg::VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/mrslz_rank.sv
`timescale 1ns / 1ps

module mrslz_rank #(
    parameter int unsigned ROWS = 8,
    parameter int unsigned RW   = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mrslz_pkg::t_beat            i_beat,
    input  logic [mrslz_pkg::VAL_W-1:0] i_data,
    input  logic                        i_sort_en,
    input  logic [RW-1:0]               i_sort_idx,
    input  logic [RW-1:0]               i_rd_pos,
    output mrslz_pkg::t_order           o_entry
);

    logic [mrslz_pkg::CNT_W-1:0] r_cnt [ROWS];
    logic [mrslz_pkg::CNT_W-1:0] r_acc;
    logic                        r_run;
    mrslz_pkg::t_order           r_order [ROWS];

    logic                        elem_zero;
    logic                        lead;
    logic                        hit;
    logic [mrslz_pkg::CNT_W-1:0] acc_base;
    logic [mrslz_pkg::CNT_W-1:0] acc_new;
    logic [mrslz_pkg::CNT_W-1:0] key;
    logic [RW:0]                 rank_sum;
    logic [RW-1:0]               rank;

    // Leading zero run of the row being streamed
    always_comb begin
        elem_zero = (i_data[mrslz_pkg::VAL_W-2:0] == '0);
        lead      = i_beat.first_col ? 1'b1 : r_run;
        acc_base  = i_beat.first_col ? '0 : r_acc;
        hit       = lead && elem_zero;
        acc_new   = acc_base + mrslz_pkg::CNT_W'(hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_acc <= '0;
            for (int r = 0; r < ROWS; r++) begin
                r_cnt[r] <= '0;
            end
        end else if (i_beat.valid) begin
            r_run <= hit;
            r_acc <= acc_new;
            if (i_beat.last_col) begin
                r_cnt[i_beat.row[RW-1:0]] <= acc_new;
            end
        end
    end

    // Stable rank: rows with a smaller count, or an equal count and a lower index
    always_comb begin
        key      = r_cnt[i_sort_idx];
        rank_sum = '0;
        for (int s = 0; s < ROWS; s++) begin
            if ((r_cnt[s] < key) || ((r_cnt[s] == key) && (RW'(s) < i_sort_idx))) begin
                rank_sum = rank_sum + (RW+1)'(1);
            end
        end
        rank = rank_sum[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_sort_en) begin
            r_order[rank] <= '{row: mrslz_pkg::ROW_W'(i_sort_idx), cnt: key};
        end
    end

    assign o_entry = r_order[i_rd_pos];

    a_rank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sort_en |-> (rank_sum < (RW+1)'(ROWS)))
        else $error("row rank beyond row count");

endmodule

FILE: rtl/core/mrslz_outq.sv
`timescale 1ns / 1ps

module mrslz_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mrslz_pkg::t_res i_res,
    input  logic            i_stall,
    output logic            o_valid,
    output mrslz_pkg::t_res o_res,
    output logic            o_room
);

    logic [1:0]      r_occ;
    logic [1:0]      n_occ;
    mrslz_pkg::t_res r_q0;
    mrslz_pkg::t_res r_q1;
    logic            pop;

    always_comb begin
        pop    = (r_occ != 2'd0) && !i_stall;
        n_occ  = r_occ + {1'b0, i_push} - {1'b0, pop};
        o_room = (n_occ <= 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 2'd0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // Head holds while stalled; drop into the tail slot when the head is busy
    always_ff @(posedge i_clk) begin
        case (r_occ)
            2'd0: begin
                if (i_push) begin
                    r_q0 <= i_res;
                end
            end
            2'd1: begin
                if (i_push && pop) begin
                    r_q0 <= i_res;
                end else if (i_push) begin
                    r_q1 <= i_res;
                end
            end
            default: begin
                if (pop) begin
                    r_q0 <= r_q1;
                end
            end
        endcase
    end

    assign o_valid = (r_occ != 2'd0);
    assign o_res   = r_q0;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_occ != 2'd2))
        else $error("result queue overflow");

endmodule

FILE: rtl/core/matrix_row_sort_by_leading_zeros_unit.sv
`timescale 1ns / 1ps

// Channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------------------
// input    | in        | i_valid / o_stall  | i_element_value, i_is_last
// result   | out       | o_valid / i_stall  | o_out_value, o_row_zero_count, o_out_last
//
// While loading, elements load at one transfer per cycle straight into the element store.
// After the last mark the block is busy: it scans the store, settles the counts, ranks
// the rows and reads the sorted matrix out; the scan and the readout share the one
// store read port.
// Synchronous active-low reset clears control state; the store is not cleared.
// o_stall is high from the last mark until the final result read is issued;
// a stall on the result side holds the readout through a two-entry queue.

module matrix_row_sort_by_leading_zeros_unit #(
    parameter int unsigned ROWS = 8,
    parameter int unsigned COLS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [mrslz_pkg::VAL_W-1:0] i_element_value,
    input  logic                        i_is_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mrslz_pkg::VAL_W-1:0] o_out_value,
    output logic [mrslz_pkg::CNT_W-1:0] o_row_zero_count,
    output logic                        o_out_last
);

    localparam int unsigned TOTAL = ROWS * COLS;
    localparam int unsigned AW    = $clog2(TOTAL);
    localparam int unsigned RW    = $clog2(ROWS);
    localparam int unsigned CLW   = (COLS > 1) ? $clog2(COLS) : 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_COUNT,
        S_WAIT,
        S_SORT,
        S_EMIT
    } t_state;

    t_state                      r_state;
    logic [AW-1:0]               r_load_pos;
    logic [RW-1:0]               r_row;
    logic [CLW-1:0]              r_col;
    mrslz_pkg::t_beat            r_beat;
    mrslz_pkg::t_beat            n_beat;
    logic                        r_e_valid;
    logic [mrslz_pkg::CNT_W-1:0] r_e_cnt;
    logic                        r_e_last;

    logic                        in_xfer;
    logic                        last_col;
    logic                        last_row;
    logic                        emit_issue;
    logic                        q_room;
    logic                        rd_en;
    logic [RW-1:0]               rd_row;
    logic [AW-1:0]               rd_addr;
    logic [mrslz_pkg::VAL_W-1:0] rd_data;
    mrslz_pkg::t_order           entry;
    mrslz_pkg::t_res             q_in;
    mrslz_pkg::t_res             q_out;

    // Input side: transfers only while loading
    assign o_stall = (r_state != S_LOAD);
    assign in_xfer = i_valid && !o_stall;

    always_comb begin
        last_col   = (r_col == CLW'(COLS - 1));
        last_row   = (r_row == RW'(ROWS - 1));
        emit_issue = (r_state == S_EMIT) && q_room;
        rd_en      = (r_state == S_COUNT) || emit_issue;
        // Scan reads physical rows in order; readout follows the sorted order table
        rd_row     = (r_state == S_EMIT) ? entry.row[RW-1:0] : r_row;
        rd_addr    = AW'(rd_row) * AW'(COLS) + AW'(r_col);
        n_beat     = '{valid:     (r_state == S_COUNT),
                       first_col: (r_col == '0),
                       last_col:  last_col,
                       row:       mrslz_pkg::ROW_W'(r_row)};
    end

    // Sequencer: load, scan, settle, rank, read out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_pos <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_beat     <= '0;
            r_e_valid  <= 1'b0;
        end else begin
            r_beat    <= n_beat;
            r_e_valid <= emit_issue;
            unique case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        if (i_is_last) begin
                            r_load_pos <= '0;
                            r_row      <= '0;
                            r_col      <= '0;
                            r_state    <= S_COUNT;
                        end else if (r_load_pos == AW'(TOTAL - 1)) begin
                            r_load_pos <= '0;
                        end else begin
                            r_load_pos <= r_load_pos + 1'b1;
                        end
                    end
                end
                S_COUNT: begin
                    if (last_col) begin
                        r_col <= '0;
                        if (last_row) begin
                            r_row   <= '0;
                            r_state <= S_WAIT;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_WAIT: begin
                    // Final row count lands this cycle
                    r_state <= S_SORT;
                end
                S_SORT: begin
                    if (last_row) begin
                        r_row   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (emit_issue) begin
                        if (last_col) begin
                            r_col <= '0;
                            if (last_row) begin
                                r_row   <= '0;
                                r_state <= S_LOAD;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Tag travelling alongside the store read
    always_ff @(posedge i_clk) begin
        if (emit_issue) begin
            r_e_cnt  <= entry.cnt;
            r_e_last <= last_row && last_col;
        end
    end

    mrslz_store #(
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr (r_load_pos),
        .i_wdata (i_element_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    mrslz_rank #(
        .ROWS (ROWS),
        .RW   (RW)
    ) u_rank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (r_beat),
        .i_data     (rd_data),
        .i_sort_en  (r_state == S_SORT),
        .i_sort_idx (r_row),
        .i_rd_pos   (r_row),
        .o_entry    (entry)
    );

    assign q_in = '{value: rd_data, cnt: r_e_cnt, last: r_e_last};

    mrslz_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_e_valid),
        .i_res   (q_in),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (q_out),
        .o_room  (q_room)
    );

    assign o_out_value      = q_out.value;
    assign o_row_zero_count = q_out.cnt;
    assign o_out_last       = q_out.last;

    a_last_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_is_last) |=> (r_state == S_COUNT))
        else $error("last mark did not start the store scan");

    a_push_from_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> $past(r_state == S_EMIT))
        else $error("result pushed outside readout");

endmodule
